>>> sv/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and helpers of the integer-to-text converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int MAX_CHARS_DEF = 33;
	localparam int CAP_WIDTH     = 7;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 7'd34;
	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ALPHA = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// register byte addresses, word select only
	localparam logic REG_BUFFER_CAPACITY = 1'b0;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] number;
		logic                   is_signed;
		logic [5:0]             radix;
	} in_word_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
		logic [1:0] status;
		logic [5:0] length;
	} out_word_t;

	// classified job passed from front to back
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] mag;
		logic                   negative;
		logic                   invalid;
		logic [5:0]             radix;
	} job_t;

	// digit value 0..35 to upper-case ASCII
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] d8;
		d8 = {2'b00, d};
		if (d < 6'd10) begin
			return CHAR_ZERO + d8;
		end
		return CHAR_ALPHA + d8 - 8'd10;
	endfunction

endpackage

>>> sv/itrt_front.sv
// ----------------------------------------------------------------------------
// itrt_front
// Accepts input words, flags bad radix or capacity, takes the magnitude.
// ----------------------------------------------------------------------------
module itrt_front import itrt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_stall,
	input  in_word_t             src_word,
	input  logic [CAP_WIDTH-1:0] buffer_capacity,
	output logic                 job_valid,
	output job_t                 job,
	input  logic                 job_full
);

	logic job_valid_q;
	job_t job_q;
	job_t job_c;
	logic push;
	logic take;

	always_comb begin
		job_c.radix    = src_word.radix;
		job_c.invalid  = (src_word.radix < RADIX_MIN) || (src_word.radix > RADIX_MAX) ||
			(buffer_capacity == '0);
		job_c.negative = src_word.is_signed & src_word.number[VALUE_WIDTH-1];
		// most negative value maps onto its unsigned magnitude
		job_c.mag      = job_c.negative ? (~src_word.number + 1'b1) : src_word.number;
	end

	assign push      = job_valid_q & ~job_full;
	assign src_stall = job_valid_q & job_full;
	assign take      = src_valid & ~src_stall;
	assign job_valid = job_valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (take) begin
			job_valid_q <= 1'b1;
		end else if (push) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= job_c;
		end
	end

endmodule

>>> sv/itrt_queue.sv
// ----------------------------------------------------------------------------
// itrt_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module itrt_queue import itrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  job_t push_job,
	output logic full,
	output logic pop_valid,
	output job_t pop_job,
	input  logic pop
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	job_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (fill_q == NW'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];
	assign do_push   = push_valid & ~full;
	assign do_pop    = pop & pop_valid;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> sv/itrt_back.sv
// ----------------------------------------------------------------------------
// itrt_back
// Bit-serial radix divider, digit store and character emitter.
// ----------------------------------------------------------------------------
module itrt_back import itrt_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  job_t                 job,
	output logic                 job_pop,
	input  logic [CAP_WIDTH-1:0] buffer_capacity,
	output logic                 dst_valid,
	input  logic                 dst_stall,
	output out_word_t            dst_word
);

	localparam int AW = $clog2(MAX_CHARS);
	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam int TW = $clog2(MAX_CHARS + 2);
	localparam int BW = $clog2(VALUE_WIDTH);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_DIV   = 8'b0000_0010,
		S_DIGIT = 8'b0000_0100,
		S_CHECK = 8'b0000_1000,
		S_SIGN  = 8'b0001_0000,
		S_READ  = 8'b0010_0000,
		S_EMIT  = 8'b0100_0000,
		S_ERR   = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [5:0]             rem_q;
	logic [5:0]             radix_q;
	logic                   neg_q;
	logic [BW-1:0]          bit_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          rd_idx_q;
	logic [TW-1:0]          total_q;
	logic [TW-1:0]          sent_q;
	logic [1:0]             err_q;
	logic [7:0]             rd_data_q;
	logic [7:0]             digit_mem [MAX_CHARS];

	logic                   out_valid_q;
	out_word_t              out_q;

	logic [6:0]    rem_sh;
	logic          ge;
	logic [6:0]    rem_sub;
	logic [TW-1:0] total_c;
	logic          ovf;
	logic          out_free;
	logic          emit;
	logic          fin;
	logic [AW-1:0] rd_addr;
	logic [TW+5:0] total_wide;

	assign rem_sh   = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge       = rem_sh >= {1'b0, radix_q};
	assign rem_sub  = rem_sh - {1'b0, radix_q};
	assign total_c  = TW'(cnt_q) + TW'(neg_q);
	assign ovf      = ({{(8-TW){1'b0}}, total_c} >= {1'b0, buffer_capacity}) ||
		(total_c > TW'(MAX_CHARS));
	assign out_free = ~out_valid_q | ~dst_stall;
	// a word is loaded into the output register this cycle
	assign emit     = out_free &
		((state_q == S_SIGN) | (state_q == S_EMIT) | (state_q == S_ERR));
	assign fin      = (sent_q + 1'b1) == total_q;
	assign rd_addr  = AW'(rd_idx_q - 1'b1);
	assign total_wide = {6'd0, total_q};
	assign job_pop  = (state_q == S_IDLE) & job_valid;

	assign dst_valid = out_valid_q;
	assign dst_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						state_q <= job.invalid ? S_ERR : S_DIV;
					end
				end
				S_DIV: begin
					if (bit_q == BW'(VALUE_WIDTH - 1)) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (quo_q == '0 || cnt_q == CW'(MAX_CHARS - 1)) begin
						state_q <= S_CHECK;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_CHECK: begin
					if (ovf) begin
						state_q <= S_ERR;
					end else if (neg_q) begin
						state_q <= S_SIGN;
					end else begin
						state_q <= S_READ;
					end
				end
				S_SIGN: begin
					if (out_free) begin
						state_q <= fin ? S_IDLE : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= fin ? S_IDLE : S_READ;
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				quo_q   <= job.mag;
				radix_q <= job.radix;
				neg_q   <= job.negative;
				rem_q   <= '0;
				bit_q   <= '0;
				cnt_q   <= '0;
				sent_q  <= '0;
				err_q   <= STAT_INVALID;
			end
			S_DIV: begin
				// restoring step: one quotient bit per cycle
				rem_q <= ge ? rem_sub[5:0] : rem_sh[5:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
				bit_q <= bit_q + 1'b1;
			end
			S_DIGIT: begin
				digit_mem[AW'(cnt_q)] <= digit_char(rem_q);
				cnt_q <= cnt_q + 1'b1;
				rem_q <= '0;
				bit_q <= '0;
			end
			S_CHECK: begin
				total_q  <= total_c;
				rd_idx_q <= cnt_q;
				err_q    <= STAT_OVERFLOW;
			end
			S_SIGN: begin
				if (out_free) begin
					out_q.character <= CHAR_MINUS;
					out_q.last      <= fin;
					out_q.status    <= STAT_OK;
					out_q.length    <= fin ? total_wide[5:0] : 6'd0;
					sent_q          <= sent_q + 1'b1;
				end
			end
			S_READ: begin
				rd_data_q <= digit_mem[rd_addr];
				rd_idx_q  <= rd_idx_q - 1'b1;
			end
			S_EMIT: begin
				if (out_free) begin
					out_q.character <= rd_data_q;
					out_q.last      <= fin;
					out_q.status    <= STAT_OK;
					out_q.length    <= fin ? total_wide[5:0] : 6'd0;
					sent_q          <= sent_q + 1'b1;
				end
			end
			S_ERR: begin
				if (out_free) begin
					out_q.character <= CHAR_NUL;
					out_q.last      <= 1'b1;
					out_q.status    <= err_q;
					out_q.length    <= 6'd0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/int_to_radix_text.sv
// ----------------------------------------------------------------------------
// int_to_radix_text
// Integer to ASCII text in radix 2..36, one word per result character.
// ----------------------------------------------------------------------------
// Usage:
//   src carries a value, a signed flag and a radix. dst returns the text,
//   most significant character first, '-' leading for negative signed
//   values. last marks the final word; length on it gives the char count.
//   Bad radix or zero capacity gives one word with status invalid; a text
//   that does not fit buffer_capacity (incl. terminator) gives one word
//   with status overflow.
//   Both channels: word moves when valid is high and stall is low.
// Flow:
//   Words pass the front register and the queue. The shared bit-serial
//   divider forms each digit from 32 quotient bits, then stores it. After
//   the overflow check the sign word, if any, goes out, then each digit is
//   read from the digit store read port and emitted; a stalled dst holds
//   the emitting step. The front keeps taking words into the queue while
//   the back converts.
// Reset: queue empty, back idle, buffer_capacity = 34. A stalled dst word
//   holds; the back waits and the queue then backs up to src_stall.
// ----------------------------------------------------------------------------
module int_to_radix_text import itrt_pkg::*; #(
	parameter int MAX_CHARS = MAX_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        src_valid,
	output logic        src_stall,
	input  in_word_t    src_word,
	// result words
	output logic        dst_valid,
	input  logic        dst_stall,
	output out_word_t   dst_word,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [CAP_WIDTH-1:0] cap_q;
	logic                 fj_valid;
	job_t                 fj;
	logic                 q_full;
	logic                 qj_valid;
	job_t                 qj;
	logic                 qj_pop;

	// one register, decoded on the word address bit
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUFFER_CAPACITY) ?
		{{(32-CAP_WIDTH){1'b0}}, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == REG_BUFFER_CAPACITY) begin
			cap_q <= pwdata[CAP_WIDTH-1:0];
		end
	end

	itrt_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.src_valid       (src_valid),
		.src_stall       (src_stall),
		.src_word        (src_word),
		.buffer_capacity (cap_q),
		.job_valid       (fj_valid),
		.job             (fj),
		.job_full        (q_full)
	);

	itrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_job   (fj),
		.full       (q_full),
		.pop_valid  (qj_valid),
		.pop_job    (qj),
		.pop        (qj_pop)
	);

	itrt_back #(
		.MAX_CHARS (MAX_CHARS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (qj_valid),
		.job             (qj),
		.job_pop         (qj_pop),
		.buffer_capacity (cap_q),
		.dst_valid       (dst_valid),
		.dst_stall       (dst_stall),
		.dst_word        (dst_word)
	);

endmodule
